// ===== rtl/lmlt_pkg.sv =====
// Package: shared types and constants for the LCD mode and line timing block.
`timescale 1ns / 1ps
`default_nettype none
package lmlt_pkg;

  // Dot counts for each part of a line
  localparam logic [9:0] DotsOam    = 10'd80;
  localparam logic [9:0] DotsXfer   = 10'd172;
  localparam logic [9:0] DotsHblank = 10'd204;
  localparam logic [9:0] DotsLine   = 10'd456;

  // Line numbers
  localparam logic [7:0] FirstVblankLine = 8'd144;
  localparam logic [7:0] LinesPerFrame   = 8'd154;

  // Field widths
  localparam int unsigned CyclesW = 6;
  localparam int unsigned DotW    = 10;
  localparam int unsigned LineW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 8;
  localparam int unsigned InDatW  = 8;
  localparam int unsigned OutDatW = 16;

  // Timing phases; the reported mode uses the same codes
  typedef enum logic [1:0] {
    PH_HBLANK = 2'd0,
    PH_VBLANK = 2'd1,
    PH_OAM    = 2'd2,
    PH_XFER   = 2'd3
  } phase_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_COMPARE    = 3'd0,
    REG_EN_HBLANK       = 3'd1,
    REG_EN_VBLANK       = 3'd2,
    REG_EN_OAM          = 3'd3,
    REG_EN_COINCIDENCE  = 3'd4
  } cfg_reg_t;

  // One result word
  typedef struct packed {
    logic       frame_done;
    logic       hblank_dma_request;
    logic       render_request;
    logic       status_request;
    logic       vblank_request;
    logic       coincidence;
    logic [7:0] line;
    phase_t     mode;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/lcd_mode_line_timing_top.sv =====
// LCD mode and line timing: dot counter, phase sequencer and line counter.
//
// Usage:
//   Input words arrive on s_axis; each carries the clocks elapsed since the
//   previous word, the double-speed flag and the display-enable bit. Every
//   accepted word produces exactly one result word on m_axis: reported mode,
//   line, coincidence flag and the request pulses (frame_done on tlast).
//   Configuration (line compare and interrupt enables) is written on the
//   cfg channel, which is always ready; write it only while the block idles.
//   Each accepted word's result goes to the output register, or to the skid
//   register while the receiver stalls. Throughput: one word per cycle
//   while s_axis_tready is high; the dot add, one compare/subtract and
//   the line update sit between the timing state and the result register.
//   The skid holds one extra result, so the block accepts during a stall;
//   once it is full, s_axis_tready drops until the receiver takes a word.
//   Reset (rst, synchronous): dots and line to 0, phase to transfer, mode 3,
//   coincidence flag and all configuration registers to 0, no result held.
`timescale 1ns / 1ps
`default_nettype none
module lcd_mode_line_timing_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] cycles, [6] speed_x2, [7] display_enable
  input  wire logic [lmlt_pkg::InDatW-1:0]  s_axis_tdata,
  // Result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [1:0] mode, [9:2] line, [10] coincidence, [11] vblank_request,
  // [12] status_request, [13] render_request, [14] hblank_dma_request,
  // [15] zero
  output logic [lmlt_pkg::OutDatW-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast,   // frame_done
  // Configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lmlt_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [lmlt_pkg::CfgDatW-1:0] cfg_data
);
  import lmlt_pkg::*;

  // Configuration registers
  logic [LineW-1:0] line_compare;
  logic             int_enable_hblank;
  logic             int_enable_vblank;
  logic             int_enable_oam;
  logic             int_enable_coincidence;

  // Timing state
  logic [DotW-1:0]  dot_count, dot_count_next;
  phase_t           phase, phase_next;
  logic [LineW-1:0] line_count, line_count_next;
  phase_t           reported_mode, reported_mode_next;
  logic             coincidence_flag, coincidence_flag_next;

  // Output and skid registers
  result_t out_res, skid_res, res_next;
  logic    out_valid, skid_valid;

  // Input word fields
  logic [CyclesW-1:0] in_cycles;
  logic               in_speed_x2;
  logic               in_display_enable;
  logic               in_accept;

  assign in_cycles         = s_axis_tdata[CyclesW-1:0];
  assign in_speed_x2       = s_axis_tdata[CyclesW];
  assign in_display_enable = s_axis_tdata[CyclesW+1];

  assign s_axis_tready = !skid_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      line_compare           <= '0;
      int_enable_hblank      <= 1'b0;
      int_enable_vblank      <= 1'b0;
      int_enable_oam         <= 1'b0;
      int_enable_coincidence <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_COMPARE:   line_compare           <= cfg_data;
        REG_EN_HBLANK:      int_enable_hblank      <= cfg_data[0];
        REG_EN_VBLANK:      int_enable_vblank      <= cfg_data[0];
        REG_EN_OAM:         int_enable_oam         <= cfg_data[0];
        REG_EN_COINCIDENCE: int_enable_coincidence <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One timing step
  logic [CyclesW-1:0] dot_add;
  logic [DotW-1:0]    dot_sum;
  logic [LineW-1:0]   line_inc;
  logic               match_inc, match_zero;
  logic               vbl, stat, render, frame;

  always_comb begin
    dot_add    = in_speed_x2 ? {1'b0, in_cycles[CyclesW-1:1]} : in_cycles;
    dot_sum    = dot_count + DotW'(dot_add);
    line_inc   = line_count + LineW'(1);
    match_inc  = (line_inc == line_compare);
    match_zero = (line_compare == '0);

    dot_count_next        = dot_count;
    phase_next            = phase;
    line_count_next       = line_count;
    reported_mode_next    = reported_mode;
    coincidence_flag_next = coincidence_flag;
    vbl    = 1'b0;
    stat   = 1'b0;
    render = 1'b0;
    frame  = 1'b0;

    if (!in_display_enable) begin
      dot_count_next     = '0;
      phase_next         = PH_XFER;
      reported_mode_next = PH_HBLANK;
      line_count_next    = '0;
    end else begin
      dot_count_next = dot_sum;
      unique case (phase)
        PH_HBLANK: begin
          if (dot_sum >= DotsHblank) begin
            dot_count_next        = dot_sum - DotsHblank;
            line_count_next       = line_inc;
            coincidence_flag_next = match_inc;
            stat = match_inc && int_enable_coincidence;
            if (line_inc == FirstVblankLine) begin
              phase_next = PH_VBLANK;
              vbl        = 1'b1;
              stat       = stat || int_enable_vblank;
            end else begin
              phase_next = PH_OAM;
              stat       = stat || int_enable_oam;
            end
            reported_mode_next = phase_next;
          end
        end
        PH_VBLANK: begin
          if (dot_sum >= DotsLine) begin
            dot_count_next        = dot_sum - DotsLine;
            line_count_next       = line_inc;
            coincidence_flag_next = match_inc;
            stat = match_inc && int_enable_coincidence;
            // Frame wrap: compare against 154 first, then against line 0
            if (line_inc == LinesPerFrame) begin
              line_count_next       = '0;
              coincidence_flag_next = match_zero;
              stat = stat || (match_zero && int_enable_coincidence) || int_enable_oam;
              phase_next         = PH_OAM;
              reported_mode_next = PH_OAM;
              frame              = 1'b1;
            end
          end
        end
        PH_OAM: begin
          if (dot_sum >= DotsOam) begin
            dot_count_next     = dot_sum - DotsOam;
            phase_next         = PH_XFER;
            reported_mode_next = PH_XFER;
          end
        end
        PH_XFER: begin
          if (dot_sum >= DotsXfer) begin
            dot_count_next     = dot_sum - DotsXfer;
            phase_next         = PH_HBLANK;
            reported_mode_next = PH_HBLANK;
            render             = 1'b1;
            stat               = int_enable_hblank;
          end
        end
        default: ;
      endcase
    end

    res_next.mode               = reported_mode_next;
    res_next.line               = line_count_next;
    res_next.coincidence        = coincidence_flag_next;
    res_next.vblank_request     = vbl;
    res_next.status_request     = stat;
    res_next.render_request     = render;
    res_next.hblank_dma_request = render;
    res_next.frame_done         = frame;
  end

  // Timing state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count        <= '0;
      phase            <= PH_XFER;
      line_count       <= '0;
      reported_mode    <= PH_XFER;
      coincidence_flag <= 1'b0;
    end else if (in_accept) begin
      dot_count        <= dot_count_next;
      phase            <= phase_next;
      line_count       <= line_count_next;
      reported_mode    <= reported_mode_next;
      coincidence_flag <= coincidence_flag_next;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid || m_axis_tready) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.frame_done;
  assign m_axis_tdata  = {1'b0, out_res[OutDatW-2:0]};

  // Checks
  a_render_dma: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.render_request |->
      out_res.hblank_dma_request && out_res.mode == PH_HBLANK)
    else $error("render pulse without dma pulse or hblank mode");

  a_frame_line0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.frame_done |-> out_res.line == '0 && out_res.mode == PH_OAM)
    else $error("frame wrap result not on line 0 in oam");

  a_vblank_entry: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.vblank_request |->
      out_res.line == FirstVblankLine && out_res.mode == PH_VBLANK)
    else $error("vblank request off line 144");

  a_skid_only_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

endmodule
`default_nettype wire
